[rtl/core/ica_pkg.sv]
// ica_pkg: operator codes and shared types for the integer calculator alu
// no dependencies
package ica_pkg;

  localparam logic [7:0] OpAdd = 8'd43;
  localparam logic [7:0] OpSub = 8'd45;
  localparam logic [7:0] OpMul = 8'd42;
  localparam logic [7:0] OpDiv = 8'd47;
  localparam logic [7:0] OpMod = 8'd37;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_MOD
  } op_kind_e;

  // per-stage control that travels with the data
  typedef struct packed {
    logic     vld;
    op_kind_e kind;
    logic     neg_q;
    logic     neg_r;
    logic     dz;
  } ctl_t;

endpackage

[rtl/core/ica_div_stage.sv]
// ica_div_stage: a group of restoring divide steps on unsigned magnitudes
// does not use ica_pkg
module ica_div_stage #(
  parameter int W     = 32,
  parameter int STEPS = 1
) (
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] dvd_i,
  input  logic [W-1:0] dvs_i,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] dvd_o
);

  always_comb begin
    logic [W:0]   trial;
    logic [W-1:0] r;
    logic [W-1:0] q;
    logic [W-1:0] d;
    r = rem_i;
    q = quo_i;
    d = dvd_i;
    for (int i = 0; i < STEPS; i++) begin
      trial = {r, d[W-1]} - {1'b0, dvs_i};
      if (!trial[W]) begin
        r = trial[W-1:0];
      end else begin
        r = {r[W-2:0], d[W-1]};
      end
      q = {q[W-2:0], ~trial[W]};
      d = {d[W-2:0], 1'b0};
    end
    rem_o = r;
    quo_o = q;
    dvd_o = d;
  end

endmodule

[rtl/core/integer_calculator_alu.sv]
// integer_calculator_alu: pipelined signed add/sub/mul/div/mod
// depends on ica_pkg and ica_div_stage
// a beat is registered in stage 0, in each divide stage, in a pass stage and at the output
// throughput: one beat per cycle unless out_ready_i stalls; the divider is unrolled into one register
// stage per DIV_STEPS quotient bits, and add/sub/mul resolve in the first divide stage then ride along
// reset clears the valid and control bits only; datapath registers are not reset
module integer_calculator_alu
  import ica_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int DIV_STEPS  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           operand_a_i,
  input  logic signed [31:0]           operand_b_i,
  input  logic [7:0]                   func_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           result_o,
  output logic                         div_by_zero_o
);

  localparam int W  = DATA_WIDTH;
  localparam int NS = (W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NP = NS + 2;

  logic adv;
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 0: decode and magnitudes
  logic [W-1:0] a_w, b_w;
  logic [63:0]  a_x, b_x;
  assign a_x = {{32{operand_a_i[31]}}, operand_a_i};
  assign b_x = {{32{operand_b_i[31]}}, operand_b_i};
  assign a_w = a_x[W-1:0];
  assign b_w = b_x[W-1:0];

  ctl_t         ctl_d;
  logic [W-1:0] ua_d, ub_d;
  always_comb begin
    ctl_d.vld = in_valid_i;
    case (func_i)
      OpAdd:   ctl_d.kind = KIND_ADD;
      OpSub:   ctl_d.kind = KIND_SUB;
      OpMul:   ctl_d.kind = KIND_MUL;
      OpDiv:   ctl_d.kind = KIND_DIV;
      OpMod:   ctl_d.kind = KIND_MOD;
      default: ctl_d.kind = KIND_ZERO;
    endcase
    ctl_d.neg_q = a_w[W-1] ^ b_w[W-1];
    ctl_d.neg_r = a_w[W-1];
    ctl_d.dz    = (b_w == '0) && (ctl_d.kind == KIND_DIV || ctl_d.kind == KIND_MOD);
    ua_d = a_w[W-1] ? (~a_w + 1'b1) : a_w;
    ub_d = b_w[W-1] ? (~b_w + 1'b1) : b_w;
  end

  ctl_t         ctl_q [NP];
  logic [W-1:0] a_q   [NP];
  logic [W-1:0] b_q   [NP];
  logic [W-1:0] rem_q [NP];
  logic [W-1:0] quo_q [NP];
  logic [W-1:0] dvd_q [NP];
  logic [W-1:0] dvs_q [NP];
  logic [W-1:0] arith_q [NP];

  // stage 0 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (adv) begin
      ctl_q[0] <= ctl_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q[0]   <= a_w;
      b_q[0]   <= b_w;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      dvd_q[0] <= ua_d;
      dvs_q[0] <= ub_d;
      arith_q[0] <= '0;
    end
  end

  // divide stages and a final pass stage, with add/sub/mul resolved in the first one
  for (genvar s = 1; s < NP; s++) begin : g_stage
    localparam int BITS = (s <= NS) ?
      (((s * DIV_STEPS) <= W) ? DIV_STEPS : (W - (s - 1) * DIV_STEPS)) : 1;
    logic [W-1:0] rem_n, quo_n, dvd_n, arith_n;
    logic [2*W-1:0] prod;
    if (s <= NS) begin : g_div
      ica_div_stage #(.W(W), .STEPS(BITS)) u_div (
        .rem_i (rem_q[s-1]), .quo_i (quo_q[s-1]), .dvd_i (dvd_q[s-1]),
        .dvs_i (dvs_q[s-1]),
        .rem_o (rem_n), .quo_o (quo_n), .dvd_o (dvd_n)
      );
    end else begin : g_pass
      assign rem_n = rem_q[s-1];
      assign quo_n = quo_q[s-1];
      assign dvd_n = dvd_q[s-1];
    end
    assign prod = a_q[s-1] * b_q[s-1];
    always_comb begin
      if (s == 1) begin
        case (ctl_q[s-1].kind)
          KIND_ADD: arith_n = a_q[s-1] + b_q[s-1];
          KIND_SUB: arith_n = a_q[s-1] - b_q[s-1];
          KIND_MUL: arith_n = prod[W-1:0];
          default:  arith_n = '0;
        endcase
      end else begin
        arith_n = arith_q[s-1];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else if (adv) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_q[s]     <= a_q[s-1];
        b_q[s]     <= b_q[s-1];
        rem_q[s]   <= rem_n;
        quo_q[s]   <= quo_n;
        dvd_q[s]   <= dvd_n;
        dvs_q[s]   <= dvs_q[s-1];
        arith_q[s] <= arith_n;
      end
    end
  end

  // final stage: sign fix, select, and zero result on a zero divisor
  ctl_t         cl;
  logic [W-1:0] res_n;
  assign cl = ctl_q[NP-1];
  always_comb begin
    case (cl.kind)
      KIND_DIV: res_n = cl.neg_q ? (~quo_q[NP-1] + 1'b1) : quo_q[NP-1];
      KIND_MOD: res_n = cl.neg_r ? (~rem_q[NP-1] + 1'b1) : rem_q[NP-1];
      default:  res_n = arith_q[NP-1];
    endcase
    if (cl.dz) begin
      res_n = '0;
    end
  end

  // narrow widths come out zero-extended
  logic [63:0] res_x;
  assign res_x = {{(64-W){1'b0}}, res_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= cl.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_o      <= res_x[31:0];
      div_by_zero_o <= cl.dz;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed under stall");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_by_zero_o |-> result_o == '0)
    else $error("zero divisor gave nonzero result");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalled with empty output");

endmodule
